### rtl/ccs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the chromaticity color segmenter.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
package ccs_pkg;

    // Field widths
    localparam int CH_W     = 8;
    localparam int COL_W    = 9;
    localparam int SUM_W    = 10;
    localparam int DARK_W   = 10;
    localparam int THR_W    = 18;
    localparam int ROW_W    = 10;
    localparam int CNT_W    = 8;
    localparam int NUM_W    = 2 * CH_W;
    localparam int SQ_W     = 2 * CH_W;
    localparam int DIST_W   = SQ_W + 1;

    // Column count store
    localparam int MAX_WIDTH = 512;
    localparam int COL_AW    = $clog2(MAX_WIDTH);
    localparam int COL_XW    = 13;

    // Divider iteration count: one quotient bit per step
    localparam int DIV_STEPS = CH_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [DARK_W-1:0] DARK_LEVEL_RST = DARK_W'(20);
    localparam logic [THR_W-1:0]  MATCH_THR_RST  = THR_W'(400);
    localparam logic [CH_W-1:0]   REF_RED_RST    = CH_W'(144);
    localparam logic [CH_W-1:0]   REF_BLUE_RST   = CH_W'(25);

    // Saturation limits
    localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        REG_DARK_LEVEL      = 2'd0,
        REG_MATCH_THRESHOLD = 2'd1,
        REG_REF_RED         = 2'd2,
        REG_REF_BLUE        = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_SQ_RED,
        S_SQ_BLUE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic [COL_AW-1:0] addr;
        logic [CNT_W-1:0]  data;
    } t_col_wr;

endpackage

### rtl/chromaticity_color_segmenter_unit.sv
`timescale 1ns / 1ps
// Chromaticity color segmenter: takes one pixel at a time, and a new pixel only once the last
// result is in the output register; a dark pixel skips the divider, a lit pixel goes through it.
// The three 255*c/sum quotients run one after another through one divider,
// 8 iterations per channel; one multiplier squares both deltas.
// Synchronous active-low reset restores register defaults and clears the row tally;
// the column count memory is not cleared.
module chromaticity_color_segmenter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ccs_pkg::CH_W-1:0]      i_red,
    input  logic [ccs_pkg::CH_W-1:0]      i_green,
    input  logic [ccs_pkg::CH_W-1:0]      i_blue,
    input  logic [ccs_pkg::COL_W-1:0]     i_column,
    input  logic                          i_first_row,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ccs_pkg::CH_W-1:0]      o_norm_red,
    output logic [ccs_pkg::CH_W-1:0]      o_norm_green,
    output logic [ccs_pkg::CH_W-1:0]      o_norm_blue,
    output logic                          o_is_dark,
    output logic                          o_is_match,
    output logic [ccs_pkg::ROW_W-1:0]     o_row_matches,
    output logic [ccs_pkg::CNT_W-1:0]     o_column_matches,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccs_pkg::APB_AW-1:0]    paddr,
    input  logic [ccs_pkg::APB_DW-1:0]    pwdata,
    output logic [ccs_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // Configuration registers
    logic [ccs_pkg::DARK_W-1:0] r_dark_level;
    logic [ccs_pkg::THR_W-1:0]  r_match_thr;
    logic [ccs_pkg::CH_W-1:0]   r_ref_red;
    logic [ccs_pkg::CH_W-1:0]   r_ref_blue;

    // Sequencer
    ccs_pkg::t_state r_state;
    ccs_pkg::t_state n_state;
    logic [1:0]      r_ch;

    // Pixel and working registers
    logic [ccs_pkg::CH_W-1:0]   r_red;
    logic [ccs_pkg::CH_W-1:0]   r_green;
    logic [ccs_pkg::CH_W-1:0]   r_blue;
    logic                       r_first;
    logic                       r_in_range;
    logic                       r_col_zero;
    logic [ccs_pkg::COL_AW-1:0] r_col_idx;
    logic [ccs_pkg::SUM_W-1:0]  r_sum;
    logic                       r_dark;
    logic [ccs_pkg::CH_W-1:0]   r_nr;
    logic [ccs_pkg::CH_W-1:0]   r_ng;
    logic [ccs_pkg::CH_W-1:0]   r_nb;
    logic [ccs_pkg::DIST_W-1:0] r_dist;
    logic [ccs_pkg::ROW_W-1:0]  r_row;

    // Output register
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [ccs_pkg::CH_W-1:0]   r_o_nr;
    logic [ccs_pkg::CH_W-1:0]   r_o_ng;
    logic [ccs_pkg::CH_W-1:0]   r_o_nb;
    logic                       r_o_dark;
    logic                       r_o_match;
    logic [ccs_pkg::ROW_W-1:0]  r_o_row;
    logic [ccs_pkg::CNT_W-1:0]  r_o_cnt;

    // Combinational
    logic                       cfg_wr;
    ccs_pkg::t_reg_idx          cfg_idx;
    logic                       in_xfer;
    logic                       out_free;
    logic                       load_out;
    logic                       div_start;
    logic [ccs_pkg::COL_XW-1:0] col_ext;
    logic [ccs_pkg::SUM_W-1:0]  in_sum;
    logic [ccs_pkg::CH_W-1:0]   div_ch;
    ccs_pkg::t_div_req          div_req;
    ccs_pkg::t_div_rsp          div_rsp;
    logic [ccs_pkg::CH_W-1:0]   d_red;
    logic [ccs_pkg::CH_W-1:0]   d_blue;
    logic [ccs_pkg::CH_W-1:0]   sq_op;
    logic [ccs_pkg::SQ_W-1:0]   sq;
    logic                       match;
    logic [ccs_pkg::CNT_W-1:0]  mem_rd;
    logic [ccs_pkg::CNT_W-1:0]  old_cnt;
    logic [ccs_pkg::CNT_W-1:0]  new_cnt;
    logic [ccs_pkg::ROW_W-1:0]  new_row;
    ccs_pkg::t_col_wr           col_wr;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = ccs_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write a register at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_level <= ccs_pkg::DARK_LEVEL_RST;
            r_match_thr  <= ccs_pkg::MATCH_THR_RST;
            r_ref_red    <= ccs_pkg::REF_RED_RST;
            r_ref_blue   <= ccs_pkg::REF_BLUE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ccs_pkg::REG_DARK_LEVEL:      r_dark_level <= pwdata[ccs_pkg::DARK_W-1:0];
                ccs_pkg::REG_MATCH_THRESHOLD: r_match_thr  <= pwdata[ccs_pkg::THR_W-1:0];
                ccs_pkg::REG_REF_RED:         r_ref_red    <= pwdata[ccs_pkg::CH_W-1:0];
                ccs_pkg::REG_REF_BLUE:        r_ref_blue   <= pwdata[ccs_pkg::CH_W-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (cfg_idx)
            ccs_pkg::REG_DARK_LEVEL:      prdata = ccs_pkg::APB_DW'(r_dark_level);
            ccs_pkg::REG_MATCH_THRESHOLD: prdata = ccs_pkg::APB_DW'(r_match_thr);
            ccs_pkg::REG_REF_RED:         prdata = ccs_pkg::APB_DW'(r_ref_red);
            ccs_pkg::REG_REF_BLUE:        prdata = ccs_pkg::APB_DW'(r_ref_blue);
        endcase
    end

    // ---------------- handshakes ----------------
    assign o_in_ready = (r_state == ccs_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign col_ext = ccs_pkg::COL_XW'(i_column);
    assign in_sum  = ccs_pkg::SUM_W'(i_red) + ccs_pkg::SUM_W'(i_green)
                   + ccs_pkg::SUM_W'(i_blue);

    // ---------------- shared arithmetic ----------------
    // Pick the channel for the divider and form 255*c
    always_comb begin
        unique case (r_ch)
            2'd0:    div_ch = r_red;
            2'd1:    div_ch = r_green;
            default: div_ch = r_blue;
        endcase
    end

    assign div_req.start = div_start;
    assign div_req.num   = {div_ch, {ccs_pkg::CH_W{1'b0}}} - ccs_pkg::NUM_W'(div_ch);
    assign div_req.den   = r_sum;

    ccs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Absolute deltas from the reference, squared one at a time
    assign d_red  = (r_nr >= r_ref_red)  ? r_nr - r_ref_red   : r_ref_red - r_nr;
    assign d_blue = (r_nb >= r_ref_blue) ? r_nb - r_ref_blue  : r_ref_blue - r_nb;
    assign sq_op  = (r_state == ccs_pkg::S_SQ_RED) ? d_red : d_blue;
    assign sq     = ccs_pkg::SQ_W'(sq_op * sq_op);

    // ---------------- match and counts ----------------
    assign match   = (ccs_pkg::THR_W'(r_dist) < r_match_thr);
    assign old_cnt = (r_first || !r_in_range) ? '0 : mem_rd;
    assign new_cnt = (old_cnt == ccs_pkg::CNT_MAX) ? ccs_pkg::CNT_MAX
                                                   : old_cnt + ccs_pkg::CNT_W'(match);

    always_comb begin
        priority if (r_col_zero) begin
            new_row = ccs_pkg::ROW_W'(match);
        end else if (r_row == ccs_pkg::ROW_MAX) begin
            new_row = ccs_pkg::ROW_MAX;
        end else begin
            new_row = r_row + ccs_pkg::ROW_W'(match);
        end
    end

    assign col_wr.we   = load_out && r_in_range;
    assign col_wr.addr = r_col_idx;
    assign col_wr.data = new_cnt;

    ccs_colmem u_colmem (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (col_ext[ccs_pkg::COL_AW-1:0]),
        .o_rd_data (mem_rd),
        .i_wr      (col_wr)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_ch        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (load_out) begin
                r_row <= new_row;
            end
            if (r_state == ccs_pkg::S_SUM) begin
                r_ch <= '0;
            end else if (r_state == ccs_pkg::S_DIV_WAIT && div_rsp.done) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ccs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = ccs_pkg::S_SUM;
                end
            end
            ccs_pkg::S_SUM: begin
                if (r_sum == '0 || r_sum < r_dark_level) begin
                    n_state = ccs_pkg::S_SQ_RED;
                end else begin
                    n_state = ccs_pkg::S_DIV_START;
                end
            end
            ccs_pkg::S_DIV_START: begin
                div_start = 1'b1;
                n_state   = ccs_pkg::S_DIV_WAIT;
            end
            ccs_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_ch == 2'd2) ? ccs_pkg::S_SQ_RED : ccs_pkg::S_DIV_START;
                end
            end
            ccs_pkg::S_SQ_RED: begin
                n_state = ccs_pkg::S_SQ_BLUE;
            end
            ccs_pkg::S_SQ_BLUE: begin
                n_state = ccs_pkg::S_UPDATE;
            end
            ccs_pkg::S_UPDATE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ccs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ccs_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result until its transfer
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        // capture the pixel
        if (in_xfer) begin
            r_red      <= i_red;
            r_green    <= i_green;
            r_blue     <= i_blue;
            r_first    <= i_first_row;
            r_sum      <= in_sum;
            r_col_zero <= (i_column == '0);
            r_in_range <= (col_ext < ccs_pkg::COL_XW'(ccs_pkg::MAX_WIDTH));
            r_col_idx  <= col_ext[ccs_pkg::COL_AW-1:0];
        end
        // classify dark and zero the normalized channels
        if (r_state == ccs_pkg::S_SUM) begin
            r_dark <= (r_sum == '0) || (r_sum < r_dark_level);
            r_nr   <= '0;
            r_ng   <= '0;
            r_nb   <= '0;
        end
        // store each quotient as it finishes
        if (r_state == ccs_pkg::S_DIV_WAIT && div_rsp.done) begin
            unique case (r_ch)
                2'd0:    r_nr <= div_rsp.quot;
                2'd1:    r_ng <= div_rsp.quot;
                default: r_nb <= div_rsp.quot;
            endcase
        end
        // accumulate the squared distance
        if (r_state == ccs_pkg::S_SQ_RED) begin
            r_dist <= ccs_pkg::DIST_W'(sq);
        end else if (r_state == ccs_pkg::S_SQ_BLUE) begin
            r_dist <= r_dist + ccs_pkg::DIST_W'(sq);
        end
        // load the output register
        if (load_out) begin
            r_o_nr    <= r_nr;
            r_o_ng    <= r_ng;
            r_o_nb    <= r_nb;
            r_o_dark  <= r_dark;
            r_o_match <= match;
            r_o_row   <= new_row;
            r_o_cnt   <= new_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_norm_red       = r_o_nr;
    assign o_norm_green     = r_o_ng;
    assign o_norm_blue      = r_o_nb;
    assign o_is_dark        = r_o_dark;
    assign o_is_match       = r_o_match;
    assign o_row_matches    = r_o_row;
    assign o_column_matches = r_o_cnt;

endmodule

### rtl/ccs_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on ccs_pkg for widths and request/response structs.
module ccs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccs_pkg::t_div_req i_req,
    output ccs_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic [ccs_pkg::DIV_CW-1:0]  r_cnt;
    logic                        r_done;
    logic [ccs_pkg::SUM_W-1:0]   r_rem;
    logic [ccs_pkg::SUM_W-1:0]   r_den;
    logic [ccs_pkg::CH_W-1:0]    r_shift;
    logic [ccs_pkg::CH_W-1:0]    r_quot;

    logic [ccs_pkg::SUM_W:0]     trial;
    logic [ccs_pkg::SUM_W:0]     diff;
    logic                        fits;
    logic                        last;

    // Trial subtract of the divisor from the shifted remainder
    assign trial = {r_rem, r_shift[ccs_pkg::CH_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});
    assign last  = (r_cnt == ccs_pkg::DIV_CW'(ccs_pkg::DIV_STEPS - 1));

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Load operands, then shift one quotient bit in per cycle.
    // The quotient is known to fit 8 bits, so the upper dividend byte
    // is already below the divisor and seeds the remainder.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= {{(ccs_pkg::SUM_W - ccs_pkg::CH_W){1'b0}},
                        i_req.num[ccs_pkg::NUM_W-1:ccs_pkg::CH_W]};
            r_shift <= i_req.num[ccs_pkg::CH_W-1:0];
            r_den   <= i_req.den;
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem   <= fits ? diff[ccs_pkg::SUM_W-1:0] : trial[ccs_pkg::SUM_W-1:0];
            r_shift <= {r_shift[ccs_pkg::CH_W-2:0], 1'b0};
            r_quot  <= {r_quot[ccs_pkg::CH_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### rtl/ccs_colmem.sv
`timescale 1ns / 1ps
// Per-column match count memory: one write port, one registered read port.
// Depends on ccs_pkg for depth, widths and the write struct.
module ccs_colmem (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [ccs_pkg::COL_AW-1:0]  i_rd_addr,
    output logic [ccs_pkg::CNT_W-1:0]   o_rd_data,
    input  ccs_pkg::t_col_wr            i_wr
);

    logic [ccs_pkg::CNT_W-1:0] mem [ccs_pkg::MAX_WIDTH];
    logic [ccs_pkg::CNT_W-1:0] r_rd_data;

    // Write the updated count
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read and hold until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ccs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the chromaticity color segmenter, bound to the top level.
// Depends on ccs_pkg for port widths.
module ccs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [ccs_pkg::CH_W-1:0]      o_norm_red,
    input  logic [ccs_pkg::CH_W-1:0]      o_norm_green,
    input  logic [ccs_pkg::CH_W-1:0]      o_norm_blue,
    input  logic                          o_is_dark,
    input  logic                          o_is_match,
    input  logic [ccs_pkg::ROW_W-1:0]     o_row_matches,
    input  logic [ccs_pkg::CNT_W-1:0]     o_column_matches
);

    // The block works on one pixel at a time: busy right after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready high right after a pixel transfer");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_norm_red) && $stable(o_norm_green)
             && $stable(o_norm_blue) && $stable(o_is_dark) && $stable(o_is_match)
             && $stable(o_row_matches) && $stable(o_column_matches)))
        else $error("stalled result changed");

    // Dark pixels carry zero chromaticity
    a_dark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_dark) |->
            (o_norm_red == '0 && o_norm_green == '0 && o_norm_blue == '0))
        else $error("dark pixel with nonzero normalized channel");

    // A match is always reflected in both counts
    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_match) |->
            (o_row_matches != '0 && o_column_matches != '0))
        else $error("match not counted");

endmodule

bind chromaticity_color_segmenter_unit ccs_checker u_ccs_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for chromaticity_color_segmenter_unit: pixel scans, config sweeps,
// back-pressure and saturation runs, each result checked against an in-bench predictor.
// Depends on rtl/ccs_pkg.sv and rtl/chromaticity_color_segmenter_unit.sv.
module tb_top;
    import ccs_pkg::*;

    localparam int HOLD_CYCLES = 700;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [COL_W-1:0] column;
        logic             first_row;
    } t_pixel;

    typedef struct {
        logic [CH_W-1:0]  norm_red;
        logic [CH_W-1:0]  norm_green;
        logic [CH_W-1:0]  norm_blue;
        logic             is_dark;
        logic             is_match;
        logic [ROW_W-1:0] row_matches;
        logic [CNT_W-1:0] column_matches;
    } t_verdict;

    // Clock, reset and block inputs, all known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [CH_W-1:0]   i_red = '0;
    logic [CH_W-1:0]   i_green = '0;
    logic [CH_W-1:0]   i_blue = '0;
    logic [COL_W-1:0]  i_column = '0;
    logic              i_first_row = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [CH_W-1:0]   o_norm_red;
    logic [CH_W-1:0]   o_norm_green;
    logic [CH_W-1:0]   o_norm_blue;
    logic              o_is_dark;
    logic              o_is_match;
    logic [ROW_W-1:0]  o_row_matches;
    logic [CNT_W-1:0]  o_column_matches;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor state: register copies, column counts, row tally
    logic [DARK_W-1:0] dark_level_q = DARK_LEVEL_RST;
    logic [THR_W-1:0]  match_thr_q = MATCH_THR_RST;
    logic [CH_W-1:0]   ref_red_q = REF_RED_RST;
    logic [CH_W-1:0]   ref_blue_q = REF_BLUE_RST;
    logic [CNT_W-1:0]  col_tally [MAX_WIDTH];
    int unsigned       row_tally_q = 0;

    // Stimulus bookkeeping
    t_pixel            pixel_backlog [$];
    t_verdict          verdict_queue [$];
    t_pixel            drv_pix;
    bit                col_written [MAX_WIDTH];
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    bit                hold_arm = 1'b0;
    logic              recv_hold = 1'b0;
    int unsigned       mismatches = 0;

    chromaticity_color_segmenter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_column         (i_column),
        .i_first_row      (i_first_row),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_norm_red       (o_norm_red),
        .o_norm_green     (o_norm_green),
        .o_norm_blue      (o_norm_blue),
        .o_is_dark        (o_is_dark),
        .o_is_match       (o_is_match),
        .o_row_matches    (o_row_matches),
        .o_column_matches (o_column_matches),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #6 i_clk = ~i_clk;

    // Print one line per mismatch (capped) and count every one
    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Normalize, measure chroma distance, and advance the row and column tallies
    function automatic t_verdict segment_pixel(input t_pixel px);
        t_verdict    v;
        int unsigned sum, nr, ng, nb, dr, db, dist_sq, prior, cnt;
        sum = px.red + px.green + px.blue;
        nr = 0;
        ng = 0;
        nb = 0;
        v.is_dark = (sum == 0) || (sum < dark_level_q);
        if (!v.is_dark) begin
            nr = (255 * px.red) / sum;
            ng = (255 * px.green) / sum;
            nb = (255 * px.blue) / sum;
        end
        dr = (nr >= ref_red_q) ? nr - ref_red_q : ref_red_q - nr;
        db = (nb >= ref_blue_q) ? nb - ref_blue_q : ref_blue_q - nb;
        dist_sq = dr * dr + db * db;
        v.is_match = (dist_sq < match_thr_q);

        // Column zero restarts the row; elsewhere saturate at the row maximum
        if (px.column == 0)
            row_tally_q = v.is_match;
        else if (row_tally_q + v.is_match <= ROW_MAX)
            row_tally_q += v.is_match;
        else
            row_tally_q = ROW_MAX;

        // Every 9-bit column lies inside the store
        prior = px.first_row ? 0 : col_tally[px.column];
        cnt = prior + v.is_match;
        if (cnt > CNT_MAX)
            cnt = CNT_MAX;
        col_tally[px.column] = CNT_W'(cnt);

        v.norm_red = CH_W'(nr);
        v.norm_green = CH_W'(ng);
        v.norm_blue = CH_W'(nb);
        v.row_matches = ROW_W'(row_tally_q);
        v.column_matches = CNT_W'(cnt);
        return v;
    endfunction

    // Drive pixel transfers from the backlog; predict each one as it is taken
    always @(posedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                verdict_queue.push_back(segment_pixel(drv_pix));
            if (!i_in_valid || o_in_ready) begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_pix = pixel_backlog.pop_front();
                    i_red <= drv_pix.red;
                    i_green <= drv_pix.green;
                    i_blue <= drv_pix.blue;
                    i_column <= drv_pix.column;
                    i_first_row <= drv_pix.first_row;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer against the oldest verdict; stall at random
    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_queue.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", 1, 0);
                end else begin
                    want = verdict_queue.pop_front();
                    if (o_norm_red !== want.norm_red)
                        flag_mismatch("norm_red", o_norm_red, want.norm_red);
                    if (o_norm_green !== want.norm_green)
                        flag_mismatch("norm_green", o_norm_green, want.norm_green);
                    if (o_norm_blue !== want.norm_blue)
                        flag_mismatch("norm_blue", o_norm_blue, want.norm_blue);
                    if (o_is_dark !== want.is_dark)
                        flag_mismatch("is_dark", o_is_dark, want.is_dark);
                    if (o_is_match !== want.is_match)
                        flag_mismatch("is_match", o_is_match, want.is_match);
                    if (o_row_matches !== want.row_matches)
                        flag_mismatch("row_matches", o_row_matches, want.row_matches);
                    if (o_column_matches !== want.column_matches)
                        flag_mismatch("column_matches", o_column_matches,
                                      want.column_matches);
                end
            end
            i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold off the receiver for a long stretch once armed, so the block backs up
    initial begin : receiver_hold
        wait (hold_arm);
        repeat (4) @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    // Write a register, update the predictor copy, then read it back
    task automatic set_reg(input t_reg_idx idx, input int unsigned value);
        logic [APB_DW-1:0] want;
        case (idx)
            REG_DARK_LEVEL: begin
                dark_level_q = DARK_W'(value);
                want = APB_DW'(dark_level_q);
            end
            REG_MATCH_THRESHOLD: begin
                match_thr_q = THR_W'(value);
                want = APB_DW'(match_thr_q);
            end
            REG_REF_RED: begin
                ref_red_q = CH_W'(value);
                want = APB_DW'(ref_red_q);
            end
            default: begin
                ref_blue_q = CH_W'(value);
                want = APB_DW'(ref_blue_q);
            end
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(idx));
        pwdata <= want;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== want)
            flag_mismatch("register readback", prdata, want);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Queue one pixel; a column never written gets first_row so no stale count is read
    task automatic queue_pixel(input int unsigned r, input int unsigned g, input int unsigned b,
                               input int unsigned col, input bit first);
        t_pixel px;
        px.red = CH_W'(r);
        px.green = CH_W'(g);
        px.blue = CH_W'(b);
        px.column = COL_W'(col);
        px.first_row = first || !col_written[px.column];
        col_written[px.column] = 1'b1;
        pixel_backlog.push_back(px);
    endtask

    function automatic int clamp_ch(input int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    // Mix of colors near the reference, near-black, and anything at all
    function automatic logic [23:0] rand_color();
        int pick, m, tr, tb, tg;
        pick = $urandom_range(99);
        if (pick < 35) begin
            m = $urandom_range(10, 255);
            tr = clamp_ch(int'(ref_red_q) + int'($urandom_range(16)) - 8);
            tb = clamp_ch(int'(ref_blue_q) + int'($urandom_range(16)) - 8);
            tg = (tr + tb >= 255) ? 0 : 255 - tr - tb;
            return {8'(tr * m / 255), 8'(tg * m / 255), 8'(tb * m / 255)};
        end else if (pick < 50) begin
            return {8'($urandom_range(12)), 8'($urandom_range(12)), 8'($urandom_range(12))};
        end
        return 24'($urandom);
    endfunction

    // Mostly raster scans (first row flagged), some scattered columns
    task automatic queue_scan(input int count);
        int left, w, h, k;
        logic [23:0] rgb;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                w = ($urandom_range(11) == 0) ? $urandom_range(2, 512) : $urandom_range(2, 48);
                h = $urandom_range(1, 4);
                for (int y = 0; y < h && left > 0; y++) begin
                    for (int x = 0; x < w && left > 0; x++) begin
                        rgb = rand_color();
                        queue_pixel(rgb[23:16], rgb[15:8], rgb[7:0], x, y == 0);
                        left--;
                    end
                end
            end else begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k && left > 0; i++) begin
                    rgb = rand_color();
                    queue_pixel(rgb[23:16], rgb[15:8], rgb[7:0], $urandom_range(511),
                                $urandom_range(1));
                    left--;
                end
            end
        end
    endtask

    task automatic set_pacing(input int unsigned send_pct, input int unsigned recv_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Wait until every queued pixel has gone through and its result came back
    task automatic drain_results();
        do
            @(negedge i_clk);
        while (pixel_backlog.size() != 0 || i_in_valid || verdict_queue.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels at reset settings
        set_pacing(0, 0);
        queue_pixel(0, 0, 0, 0, 1);         // zero sum
        queue_pixel(255, 255, 255, 1, 1);
        queue_pixel(255, 0, 0, 2, 1);
        queue_pixel(0, 255, 0, 3, 1);
        queue_pixel(0, 0, 255, 4, 1);
        queue_pixel(144, 86, 25, 5, 1);     // exactly on the reference
        queue_pixel(144, 86, 25, 5, 0);
        queue_pixel(72, 43, 12, 5, 0);
        queue_pixel(6, 6, 7, 6, 1);         // one below the dark level
        queue_pixel(7, 7, 6, 7, 1);         // right at the dark level
        queue_pixel(255, 255, 255, 511, 1);
        queue_pixel(144, 86, 25, 511, 0);
        queue_pixel(144, 86, 25, 0, 0);     // row restart on a match
        queue_pixel(1, 0, 0, 8, 1);
        queue_pixel(164, 66, 25, 9, 1);     // distance equal to threshold
        queue_pixel(163, 67, 25, 10, 1);    // just inside threshold
        drain_results();

        // Random settings, sender idling
        set_reg(REG_DARK_LEVEL, $urandom_range(765));
        set_reg(REG_MATCH_THRESHOLD, $urandom_range(6000));
        set_reg(REG_REF_RED, $urandom_range(255));
        set_reg(REG_REF_BLUE, $urandom_range(255));
        set_pacing(55, 0);
        queue_scan(150);
        drain_results();

        // Dark level zero: only a zero sum is dark; receiver stalling
        set_reg(REG_DARK_LEVEL, 0);
        set_reg(REG_MATCH_THRESHOLD, 2000);
        set_reg(REG_REF_RED, $urandom_range(255));
        set_pacing(0, 55);
        queue_pixel(0, 0, 0, 0, 1);
        queue_pixel(1, 0, 0, 1, 1);
        queue_pixel(0, 0, 1, 2, 1);
        queue_scan(150);
        drain_results();

        // Threshold zero never matches; reference at opposite corners
        set_reg(REG_DARK_LEVEL, $urandom_range(40));
        set_reg(REG_MATCH_THRESHOLD, 0);
        set_reg(REG_REF_RED, 0);
        set_reg(REG_REF_BLUE, 255);
        set_pacing(10, 10);
        queue_scan(120);
        drain_results();

        // Back-pressure: receiver held off while the sender keeps offering
        set_reg(REG_DARK_LEVEL, DARK_LEVEL_RST);
        set_reg(REG_MATCH_THRESHOLD, MATCH_THR_RST);
        set_reg(REG_REF_RED, REF_RED_RST);
        set_reg(REG_REF_BLUE, REF_BLUE_RST);
        set_pacing(0, 0);
        hold_arm = 1'b1;
        queue_scan(150);
        drain_results();

        // Everything matches: saturate one column count
        set_reg(REG_DARK_LEVEL, 765);
        set_reg(REG_MATCH_THRESHOLD, 131072);
        set_reg(REG_REF_RED, 255);
        set_reg(REG_REF_BLUE, 255);
        set_pacing(10, 10);
        queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), 0, 1);
        for (int i = 0; i < 270; i++)
            queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                        3, i == 0);
        drain_results();

        // Random settings again, light idling on both sides
        set_reg(REG_DARK_LEVEL, $urandom_range(765));
        set_reg(REG_MATCH_THRESHOLD, $urandom_range(131072));
        set_reg(REG_REF_RED, $urandom_range(255));
        set_reg(REG_REF_BLUE, $urandom_range(255));
        set_pacing(10, 10);
        queue_scan(100);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (verdict_queue.size() != 0)
            flag_mismatch("results never delivered", 0, verdict_queue.size());
        if (mismatches == 0) begin
            $display("** chromaticity_color_segmenter_unit: PASSED **");
        end else begin
            $display("** chromaticity_color_segmenter_unit: FAILED **");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #5_000_000;
        $display("** chromaticity_color_segmenter_unit: FAILED **");
        $finish;
    end

endmodule

### chromaticity_color_segmenter_unit.f
rtl/ccs_pkg.sv
rtl/ccs_div.sv
rtl/ccs_colmem.sv
rtl/chromaticity_color_segmenter_unit.sv
rtl/ccs_checker.sv
tb/sv/tb_top.sv
